[hdl/lookahead_iir_biquad_macros.svh]
// Assertion helpers shared by the filter RTL.
`ifndef LOOKAHEAD_IIR_BIQUAD_MACROS_SVH
`define LOOKAHEAD_IIR_BIQUAD_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LIIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LIIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/liir_pkg.sv]
package liir_pkg;

    // Defaults for the top-level parameters
    localparam int DATA_WIDTH_DEF   = 12;
    localparam int SHIFT_ADJUST_DEF = 1;

    // Width of the intermediate w values and of the delay line
    localparam int W_WIDTH = 16;

    // Coefficient register file
    localparam int NUM_REGS = 5;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    localparam int B0_RESET = 423;
    localparam int B1_RESET = 846;
    localparam int B2_RESET = 423;
    localparam int A1_RESET = -757;
    localparam int A2_RESET = 401;

    // Look-ahead coefficients derived from the registers
    typedef enum logic [2:0] {
        DER_A1A1 = 3'd0,
        DER_A1A2 = 3'd1,
        DER_A1B0 = 3'd2,
        DER_A1B1 = 3'd3,
        DER_A1B2 = 3'd4
    } t_der_idx;

    // What the accumulate stage does with a finished product
    typedef enum logic [2:0] {
        OP_DER   = 3'd0,
        OP_SUB   = 3'd1,
        OP_FIRST = 3'd2,
        OP_ADD   = 3'd3,
        OP_LAST  = 3'd4
    } t_acc_op;

    // Sequencer steps: derive look-ahead terms, then the taps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DERIVE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST_TAP = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd14;

    // One multiply issued to the shared unit
    typedef struct packed {
        logic     valid;
        t_acc_op  op;
        t_der_idx der;
    } t_mac_ctl;

endpackage

[hdl/liir_ifs.sv]
// Input sample channel
interface liir_in_if #(
    parameter int DATA_WIDTH = liir_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// Output sample channel
interface liir_out_if #(
    parameter int DATA_WIDTH = liir_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[hdl/liir_mac.sv]
// Shared multiplier with a registered product and an accumulate stage.
// Products are arithmetically shifted right by SH before use.
module liir_mac #(
    parameter int DATA_WIDTH   = liir_pkg::DATA_WIDTH_DEF,
    parameter int SHIFT_ADJUST = liir_pkg::SHIFT_ADJUST_DEF,
    localparam int AW = (liir_pkg::W_WIDTH > DATA_WIDTH) ? liir_pkg::W_WIDTH : DATA_WIDTH,
    localparam int BW = DATA_WIDTH + 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic signed [DATA_WIDTH-1:0]       i_sample,
    input  liir_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [AW-1:0]               i_a,
    input  logic signed [BW-1:0]               i_b,
    input  logic                               i_hold,
    output logic                               o_der_we,
    output liir_pkg::t_der_idx                 o_der_idx,
    output logic signed [BW-1:0]               o_der_val,
    output logic signed [liir_pkg::W_WIDTH-1:0] o_w,
    output logic                               o_y_valid,
    output logic signed [DATA_WIDTH-1:0]       o_y
);

    localparam int SH  = DATA_WIDTH + SHIFT_ADJUST - 1;
    localparam int PW  = AW + BW;
    localparam int ACW = PW + 4;
    localparam int WW  = liir_pkg::W_WIDTH;

    localparam logic signed [ACW-1:0] W_MAX = ACW'(2 ** (WW - 1) - 1);
    localparam logic signed [ACW-1:0] W_MIN = ACW'(-(2 ** (WW - 1)));
    localparam logic signed [ACW-1:0] Y_MAX = ACW'(2 ** (DATA_WIDTH - 1) - 1);
    localparam logic signed [ACW-1:0] Y_MIN = ACW'(-(2 ** (DATA_WIDTH - 1)));

    liir_pkg::t_mac_ctl      r_ctl;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACW-1:0]   r_acc;
    logic signed [WW-1:0]    r_w;

    logic                    advance;
    logic signed [PW-1:0]    term;
    logic signed [ACW-1:0]   term_x;
    logic signed [ACW-1:0]   y_sum;
    logic signed [WW-1:0]    w_sat;

    // The final product waits here while the output register is full and not taken
    assign advance = !(r_ctl.valid && (r_ctl.op == liir_pkg::OP_LAST) && i_hold);
    assign term    = r_prod >>> SH;
    assign term_x  = ACW'(term);
    assign y_sum   = r_acc + term_x;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, op: liir_pkg::OP_DER, der: liir_pkg::DER_A1A1};
        end else if (advance) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    // Saturate the feedback sum to the w range
    always_comb begin
        priority if (r_acc > W_MAX) begin
            w_sat = W_MAX[WW-1:0];
        end else if (r_acc < W_MIN) begin
            w_sat = W_MIN[WW-1:0];
        end else begin
            w_sat = r_acc[WW-1:0];
        end
    end

    // Saturate the output sum
    always_comb begin
        priority if (y_sum > Y_MAX) begin
            o_y = Y_MAX[DATA_WIDTH-1:0];
        end else if (y_sum < Y_MIN) begin
            o_y = Y_MIN[DATA_WIDTH-1:0];
        end else begin
            o_y = y_sum[DATA_WIDTH-1:0];
        end
    end

    // Accumulate stage: feedback sum first, then w, then feed-forward sum
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= ACW'(i_sample);
        end else if (r_ctl.valid && advance) begin
            unique case (r_ctl.op)
                liir_pkg::OP_SUB: begin
                    r_acc <= r_acc - term_x;
                end
                liir_pkg::OP_FIRST: begin
                    r_w   <= w_sat;
                    r_acc <= term_x;
                end
                liir_pkg::OP_ADD: begin
                    r_acc <= r_acc + term_x;
                end
                liir_pkg::OP_DER, liir_pkg::OP_LAST: begin
                    r_acc <= r_acc;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_der_we  = r_ctl.valid && (r_ctl.op == liir_pkg::OP_DER);
    assign o_der_idx = r_ctl.der;
    assign o_der_val = term[BW-1:0];
    assign o_w       = r_w;
    assign o_y_valid = r_ctl.valid && (r_ctl.op == liir_pkg::OP_LAST) && advance;

endmodule

[hdl/lookahead_iir_biquad.sv]
// Second-order IIR filter, direct form II with one-step look-ahead. One signed
// sample in gives one saturated sample out. All products go through a single
// shared multiplier under a step sequencer: ten multiplies per sample (nine
// taps plus w*b0). A new sample is accepted only once the previous result
// sits in the output register. The first sample after reset or after any
// coefficient write runs five more multiplies first, which derive the
// look-ahead coefficients (a1*a1, a1*a2, a1*b0, a1*b1, a1*b2). The input
// is taken while a finished result still waits in the output register; while
// that result is not taken, the next sample stalls on its last multiply.
// Coefficients sit at byte addresses 0, 4, 8, 12, 16 (b0, b1, b2, a1, a2) and
// must be written only while the filter is idle.
`include "lookahead_iir_biquad_macros.svh"

module lookahead_iir_biquad #(
    parameter int DATA_WIDTH   = liir_pkg::DATA_WIDTH_DEF,
    parameter int SHIFT_ADJUST = liir_pkg::SHIFT_ADJUST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    liir_in_if.sink                         i_in,
    liir_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [liir_pkg::PADDR_W-1:0]    paddr,
    input  logic [liir_pkg::PDATA_W-1:0]    pwdata,
    output logic [liir_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int AW = (liir_pkg::W_WIDTH > DATA_WIDTH) ? liir_pkg::W_WIDTH : DATA_WIDTH;
    localparam int BW = DATA_WIDTH + 1;
    localparam int WW = liir_pkg::W_WIDTH;

    localparam logic signed [DATA_WIDTH-1:0] RST_B0 = DATA_WIDTH'(liir_pkg::B0_RESET);
    localparam logic signed [DATA_WIDTH-1:0] RST_B1 = DATA_WIDTH'(liir_pkg::B1_RESET);
    localparam logic signed [DATA_WIDTH-1:0] RST_B2 = DATA_WIDTH'(liir_pkg::B2_RESET);
    localparam logic signed [DATA_WIDTH-1:0] RST_A1 = DATA_WIDTH'(liir_pkg::A1_RESET);
    localparam logic signed [DATA_WIDTH-1:0] RST_A2 = DATA_WIDTH'(liir_pkg::A2_RESET);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [liir_pkg::STEP_W-1:0]     r_step;
    logic                            r_dirty;
    logic signed [DATA_WIDTH-1:0]    r_coef [liir_pkg::NUM_REGS];
    logic signed [BW-1:0]            r_der  [liir_pkg::NUM_REGS];
    logic signed [WW-1:0]            r_line [3];
    logic                            r_out_valid;
    logic signed [DATA_WIDTH-1:0]    r_out_data;

    logic                            in_xfer;
    logic                            cfg_wr;
    logic [2:0]                      cfg_idx;
    logic                            cfg_hit;
    liir_pkg::t_mac_ctl              mac_ctl;
    logic signed [AW-1:0]            mac_a;
    logic signed [BW-1:0]            mac_b;
    logic                            hold;
    logic                            der_we;
    liir_pkg::t_der_idx              der_idx;
    logic signed [BW-1:0]            der_val;
    logic signed [WW-1:0]            w_val;
    logic                            y_valid;
    logic signed [DATA_WIDTH-1:0]    y_val;

    // Register port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[liir_pkg::PADDR_W-1:2];
    assign cfg_hit = (cfg_idx < 3'(liir_pkg::NUM_REGS));
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        if (cfg_hit) begin
            prdata = liir_pkg::PDATA_W'(r_coef[cfg_idx]);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[liir_pkg::REG_B0] <= RST_B0;
            r_coef[liir_pkg::REG_B1] <= RST_B1;
            r_coef[liir_pkg::REG_B2] <= RST_B2;
            r_coef[liir_pkg::REG_A1] <= RST_A1;
            r_coef[liir_pkg::REG_A2] <= RST_A2;
        end else if (cfg_wr && cfg_hit) begin
            r_coef[cfg_idx] <= pwdata[DATA_WIDTH-1:0];
        end
    end

    // Look-ahead coefficients need recomputing after reset or a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b1;
        end else if (cfg_wr && cfg_hit) begin
            r_dirty <= 1'b1;
        end else if (in_xfer) begin
            r_dirty <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (der_we) begin
            r_der[der_idx] <= der_val;
        end
    end

    // Sequencer
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == liir_pkg::STEP_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (y_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= liir_pkg::STEP_DERIVE;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_step <= r_dirty ? liir_pkg::STEP_DERIVE : liir_pkg::STEP_FIRST_TAP;
            end else if (r_state == ST_RUN) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Operand selection for each step
    always_comb begin
        mac_ctl.valid = (r_state == ST_RUN);
        mac_ctl.der   = liir_pkg::DER_A1A1;
        mac_ctl.op    = liir_pkg::OP_DER;
        mac_a         = AW'(r_coef[liir_pkg::REG_A1]);
        mac_b         = BW'(r_coef[liir_pkg::REG_A1]);
        unique case (r_step)
            4'd0: begin
                mac_ctl.der = liir_pkg::DER_A1A1;
            end
            4'd1: begin
                mac_b       = BW'(r_coef[liir_pkg::REG_A2]);
                mac_ctl.der = liir_pkg::DER_A1A2;
            end
            4'd2: begin
                mac_b       = BW'(r_coef[liir_pkg::REG_B0]);
                mac_ctl.der = liir_pkg::DER_A1B0;
            end
            4'd3: begin
                mac_b       = BW'(r_coef[liir_pkg::REG_B1]);
                mac_ctl.der = liir_pkg::DER_A1B1;
            end
            4'd4: begin
                mac_b       = BW'(r_coef[liir_pkg::REG_B2]);
                mac_ctl.der = liir_pkg::DER_A1B2;
            end
            4'd5: begin
                mac_a      = AW'(r_line[0]);
                mac_ctl.op = liir_pkg::OP_SUB;
            end
            4'd6: begin
                mac_a      = AW'(r_line[1]);
                mac_b      = r_der[liir_pkg::DER_A1A1];
                mac_ctl.op = liir_pkg::OP_SUB;
            end
            4'd7: begin
                mac_a      = AW'(r_line[1]);
                mac_b      = BW'(r_coef[liir_pkg::REG_A2]);
                mac_ctl.op = liir_pkg::OP_SUB;
            end
            4'd8: begin
                mac_a      = AW'(r_line[2]);
                mac_b      = r_der[liir_pkg::DER_A1A2];
                mac_ctl.op = liir_pkg::OP_SUB;
            end
            4'd9: begin
                mac_a      = AW'(r_line[0]);
                mac_b      = r_der[liir_pkg::DER_A1B0];
                mac_ctl.op = liir_pkg::OP_FIRST;
            end
            4'd10: begin
                mac_a      = AW'(r_line[0]);
                mac_b      = BW'(r_coef[liir_pkg::REG_B1]);
                mac_ctl.op = liir_pkg::OP_ADD;
            end
            4'd11: begin
                mac_a      = AW'(r_line[1]);
                mac_b      = r_der[liir_pkg::DER_A1B1];
                mac_ctl.op = liir_pkg::OP_ADD;
            end
            4'd12: begin
                mac_a      = AW'(r_line[1]);
                mac_b      = BW'(r_coef[liir_pkg::REG_B2]);
                mac_ctl.op = liir_pkg::OP_ADD;
            end
            4'd13: begin
                mac_a      = AW'(r_line[2]);
                mac_b      = r_der[liir_pkg::DER_A1B2];
                mac_ctl.op = liir_pkg::OP_ADD;
            end
            4'd14: begin
                mac_a      = AW'(w_val);
                mac_b      = BW'(r_coef[liir_pkg::REG_B0]);
                mac_ctl.op = liir_pkg::OP_LAST;
            end
            default: begin
                mac_ctl.valid = 1'b0;
            end
        endcase
    end

    assign hold = r_out_valid && !o_out.ready;

    liir_mac #(
        .DATA_WIDTH   (DATA_WIDTH),
        .SHIFT_ADJUST (SHIFT_ADJUST)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_xfer),
        .i_sample  (i_in.sample_in),
        .i_ctl     (mac_ctl),
        .i_a       (mac_a),
        .i_b       (mac_b),
        .i_hold    (hold),
        .o_der_we  (der_we),
        .o_der_idx (der_idx),
        .o_der_val (der_val),
        .o_w       (w_val),
        .o_y_valid (y_valid),
        .o_y       (y_val)
    );

    // Delay line shifts once the sample is finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line[0] <= '0;
            r_line[1] <= '0;
            r_line[2] <= '0;
        end else if (y_valid) begin
            r_line[0] <= w_val;
            r_line[1] <= r_line[0];
            r_line[2] <= r_line[1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (y_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (y_valid) begin
            r_out_data <= y_val;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    `LIIR_ASSERT_NOW(a_result_in_drain, i_clk, i_rst_n, y_valid, r_state == ST_DRAIN, "result outside drain")
    `LIIR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, y_valid, !r_out_valid || o_out.ready, "pending result overwritten")
    `LIIR_ASSERT_NEXT(a_start_step, i_clk, i_rst_n, in_xfer, (r_step == liir_pkg::STEP_DERIVE) || (r_step == liir_pkg::STEP_FIRST_TAP), "bad start step")
    `LIIR_ASSERT_NEXT(a_write_dirty, i_clk, i_rst_n, cfg_wr && cfg_hit, r_dirty, "coefficient write not flagged")

endmodule

[dv/testbench.sv]
module testbench;

    localparam int DW        = liir_pkg::DATA_WIDTH_DEF;
    localparam int SH        = liir_pkg::DATA_WIDTH_DEF + liir_pkg::SHIFT_ADJUST_DEF - 1;
    localparam int AW        = liir_pkg::PADDR_W;
    localparam int PW        = liir_pkg::PDATA_W;
    localparam int NREGS     = liir_pkg::NUM_REGS;
    localparam int LINE_LEN  = 3;
    // Latency of one sample incl. the look-ahead derivation, with margin
    localparam int SETTLE    = 40;
    localparam int LIMIT     = 600000;
    localparam int IDLE_PCT  = 31;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 400;
    localparam int PHASE_LEN = 102;

    typedef logic signed [DW-1:0] t_sample;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [AW-1:0] paddr   = '0;
    logic [PW-1:0] pwdata  = '0;
    logic [PW-1:0] prdata;
    logic          pready;

    liir_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    liir_out_if #(.DATA_WIDTH(DW)) out_ch ();

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        out_ch.ready    = 1'b0;
    end

    lookahead_iir_biquad #(
        .DATA_WIDTH  (DW),
        .SHIFT_ADJUST(liir_pkg::SHIFT_ADJUST_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Filter model state
    longint  coef_q [NREGS];
    longint  w_line [LINE_LEN];
    t_sample pending_q [$];
    t_sample expected_q [$];
    int      n_errors   = 0;
    int      n_accepted = 0;
    int      cycles     = 0;
    int      hold_left  = 0;
    bit      hold_done  = 1'b0;
    bit      calm       = 1'b0;

    function automatic longint scale(longint v);
        return v >>> SH;
    endfunction

    function automatic longint clamp(longint v, int width);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (width - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One sample through the look-ahead biquad; advances the w line
    function automatic t_sample filter_step(t_sample x_in);
        longint b0, b1, b2, a1, a2, d0, d1, d2;
        longint la_a1a1, la_a1a2, la_a1b0, la_a1b1, la_a1b2;
        longint fb, ff, w, y;
        b0 = coef_q[liir_pkg::REG_B0];
        b1 = coef_q[liir_pkg::REG_B1];
        b2 = coef_q[liir_pkg::REG_B2];
        a1 = coef_q[liir_pkg::REG_A1];
        a2 = coef_q[liir_pkg::REG_A2];
        d0 = w_line[0];
        d1 = w_line[1];
        d2 = w_line[2];
        la_a1a1 = scale(a1 * a1);
        la_a1a2 = scale(a1 * a2);
        la_a1b0 = scale(a1 * b0);
        la_a1b1 = scale(a1 * b1);
        la_a1b2 = scale(a1 * b2);
        fb = -scale(d0 * a1) - scale(d1 * la_a1a1) - scale(d1 * a2) - scale(d2 * la_a1a2);
        ff = scale(d0 * la_a1b0) + scale(d0 * b1) + scale(d1 * la_a1b1)
           + scale(d1 * b2) + scale(d2 * la_a1b2);
        w = clamp(longint'(x_in) + fb, liir_pkg::W_WIDTH);
        y = clamp(scale(w * b0) + ff, DW);
        w_line[2] = d1;
        w_line[1] = d0;
        w_line[0] = w;
        return t_sample'(y);
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycles);
        n_errors++;
    endtask

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("lookahead_iir_biquad verification failed");
            $finish;
        end
    end

    // Input driver: predict on each accepted transfer, then offer the next sample
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_q.push_back(filter_step(in_ch.sample_in));
                n_accepted <= n_accepted + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && !roll_idle()) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.sample_in <= pending_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the filter backs up and stalls its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Output monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected output sample", 0, out_ch.sample_out);
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.sample_out !== want)
                        report_mismatch("sample_out", want, out_ch.sample_out);
                end
            end
            out_ch.ready <= (hold_left == 0) && !roll_idle();
        end
    end

    // Register write; index past the register file is accepted and dropped
    task automatic apb_write(int idx, int val);
        logic [PW-1:0] data;
        t_sample       field;
        data          = $urandom;
        data[DW-1:0]  = val[DW-1:0];
        field         = data[DW-1:0];
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < NREGS) coef_q[idx] = field;
    endtask

    task automatic apb_check(liir_pkg::t_reg_idx idx);
        logic [PW-1:0] got;
        t_sample       want;
        want = t_sample'(coef_q[idx]);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AW'(4 * int'(idx));
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[DW-1:0] !== want)
            report_mismatch($sformatf("readback of register %s", idx.name()),
                            want, t_sample'(got[DW-1:0]));
    endtask

    task automatic set_coefs(int b0, int b1, int b2, int a1, int a2);
        liir_pkg::t_reg_idx r;
        apb_write(liir_pkg::REG_B0, b0);
        apb_write(liir_pkg::REG_B1, b1);
        apb_write(liir_pkg::REG_B2, b2);
        apb_write(liir_pkg::REG_A1, a1);
        apb_write(liir_pkg::REG_A2, a2);
        r = r.first();
        forever begin
            apb_check(r);
            if (r == r.last()) break;
            r = r.next();
        end
    endtask

    // Nothing queued, nothing in flight, then let the pipeline go quiet
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || expected_q.size() != 0 || in_ch.valid);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return t_sample'(2047);
            1:       return t_sample'(-2048);
            2:       return t_sample'($urandom_range(31)) - t_sample'(16);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Random stream with occasional constant runs to drive the output into clipping
    task automatic queue_random(int count);
        t_sample v;
        int      run;
        int      k;
        k = 0;
        while (k < count) begin
            v   = pick_sample();
            run = ($urandom_range(7) == 0) ? $urandom_range(20, 8) : 1;
            repeat (run) begin
                pending_q.push_back(v);
                k++;
            end
        end
    endtask

    function automatic int rand_coef();
        case ($urandom_range(5))
            0:       return 2047;
            1:       return -2048;
            default: return $urandom_range(4095) - 2048;
        endcase
    endfunction

    // Stimulus sequence
    initial begin
        t_sample directed [];
        directed = '{2047, -2048, 0, 1, -1, 0, 0, 0,
                     2047, 2047, 2047, 2047, 2047, 2047,
                     -2048, -2048, -2048, -2048, -2048, -2048,
                     2047, -2048, 2047, -2048};
        coef_q[liir_pkg::REG_B0] = liir_pkg::B0_RESET;
        coef_q[liir_pkg::REG_B1] = liir_pkg::B1_RESET;
        coef_q[liir_pkg::REG_B2] = liir_pkg::B2_RESET;
        coef_q[liir_pkg::REG_A1] = liir_pkg::A1_RESET;
        coef_q[liir_pkg::REG_A2] = liir_pkg::A2_RESET;
        foreach (w_line[i]) w_line[i] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients, directed extremes, impulse and steps
        foreach (directed[i]) pending_q.push_back(directed[i]);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_coefs(2047, 2047, 2047, 2047, 2047);
                1: set_coefs(-2048, -2048, -2048, -2048, -2048);
                2: set_coefs(2047, 2047, 2047, -2048, -2048);
                3: set_coefs(-2048, 2047, -2048, 2047, -2048);
                4: set_coefs(0, 0, 0, 0, 0);
                default: set_coefs(rand_coef(), rand_coef(), rand_coef(),
                                   rand_coef(), rand_coef());
            endcase
            // Writes past the register file must leave the coefficients alone
            if (ph == 3 || ph == 8) begin
                apb_write(NREGS + $urandom_range(2), $urandom);
                apb_check(liir_pkg::REG_B0);
            end
            calm <= (ph == 2);
            queue_random(PHASE_LEN);
            wait_drained();
            calm <= 1'b0;
        end

        if (n_errors == 0) begin
            $display("lookahead_iir_biquad verification clean");
        end else begin
            $display("lookahead_iir_biquad verification failed");
        end
        $finish;
    end

endmodule
